FILE: hdl/record_range_lock_table_unit_defines.svh
// assertion macros used by the lock table checker
`ifndef RECORD_RANGE_LOCK_TABLE_UNIT_DEFINES_SVH
`define RECORD_RANGE_LOCK_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define RRLT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RRLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rrlt_pkg.sv
// package with widths, codes and shared types of the record lock table
package rrlt_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int SCNT_W    = 11;
	localparam int REC_W     = 31;
	localparam int RUN_W     = REC_W + 1;
	localparam int ID_W      = 15;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int STEP_W    = $clog2(REC_W);

	localparam logic REQ_LOCK  = 1'b0;
	localparam logic REQ_FREE  = 1'b1;
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_BUSY = 1'b1;

	localparam logic REG_RECORD_COUNT = 1'b0;
	localparam logic REG_SLOT_COUNT   = 1'b1;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [ID_W-1:0]   wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} ram_cmd_t;

	// slot count in use: zero taken as one, clamped to the table size
	function automatic logic [CNT_W-1:0] slots_in_use(input logic [SCNT_W-1:0] sc);
		logic [CNT_W-1:0] n;
		if (sc == '0) begin
			n = CNT_W'(1);
		end else if (32'(sc) > 32'(MAX_SLOTS)) begin
			n = CNT_W'(MAX_SLOTS);
		end else begin
			n = CNT_W'(sc);
		end
		return n;
	endfunction

endpackage

FILE: hdl/rrlt_if.sv
// request and response channel interfaces of the record lock table
interface rrlt_req_if import rrlt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [REC_W-1:0] record_number;
	logic [ID_W-1:0]  thread_id;

	modport source (output valid, req_type, record_number, thread_id, input ready);
	modport sink (input valid, req_type, record_number, thread_id, output ready);
endinterface

interface rrlt_rsp_if import rrlt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            status;
	logic [ID_W-1:0] holder_id;

	modport source (output valid, status, holder_id, input ready);
	modport sink (input valid, status, holder_id, output ready);
endinterface

FILE: hdl/record_range_lock_table_unit.sv
// Record range lock table, top level.
// Requests come in on req (valid/ready): req_type selects a lock of
// record_number for thread_id, or a release of every slot in use owned by thread_id.
// Each item gives exactly one response on rsp: status ok, or busy with the
// owner of the slot in holder_id.
// Registers on the APB port: record_count at 0x0, slot_count at 0x4; write
// them only while no item is in flight.
// A lock item runs two serial 31-step divisions (run length, then slot
// index) and one read-modify-write of the owner memory. A free item walks
// the slots in use, one memory read a cycle, each slot written back in the
// cycle after its read.
// One item is handled at a time; req.ready is high only while idle.
// After reset the owner memory is cleared, one slot a cycle, with req.ready
// low; configuration writes are taken throughout.
// The response sits in an output register; while rsp.ready is low the block
// still takes the next item and holds its result until the register drains.
module record_range_lock_table_unit import rrlt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	rrlt_req_if.sink          req,
	rrlt_rsp_if.source        rsp
);

	logic [REC_W-1:0]  record_count_q;
	logic [SCNT_W-1:0] slot_count_q;
	logic              wr_en;

	logic              div_start;
	logic [REC_W-1:0]  div_dividend;
	logic [RUN_W-1:0]  div_divisor;
	logic              div_done;
	logic [REC_W-1:0]  div_quotient;
	ram_cmd_t          ram_cmd;
	logic [ID_W-1:0]   ram_rdata;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= '0;
			slot_count_q   <= SCNT_W'(MAX_SLOTS);
		end else if (wr_en) begin
			if (paddr[2] == REG_RECORD_COUNT) begin
				record_count_q <= pwdata[REC_W-1:0];
			end else begin
				slot_count_q <= pwdata[SCNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_SLOT_COUNT) begin
			prdata = DATA_W'(slot_count_q);
		end else begin
			prdata = DATA_W'(record_count_q);
		end
	end

	rrlt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.record_count  (record_count_q),
		.slot_count    (slot_count_q),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.req_type      (req.req_type),
		.record_number (req.record_number),
		.thread_id     (req.thread_id),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.status        (rsp.status),
		.holder_id     (rsp.holder_id),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_done      (div_done),
		.div_quotient  (div_quotient),
		.ram_cmd       (ram_cmd),
		.ram_rdata     (ram_rdata)
	);

	rrlt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	rrlt_owner_ram u_ram (
		.clk   (clk),
		.cmd   (ram_cmd),
		.rdata (ram_rdata)
	);

endmodule

FILE: hdl/rrlt_div.sv
// restoring divider, one quotient bit per cycle
module rrlt_div import rrlt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REC_W-1:0] dividend,
	input  logic [RUN_W-1:0] divisor,
	output logic             done,
	output logic [REC_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REC_W-1:0]  dvd_q;
	logic [RUN_W-2:0]  rem_q;
	logic [RUN_W-1:0]  dvs_q;
	logic [RUN_W-1:0]  trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, dvd_q[REC_W-1]};
		ge    = trial >= dvs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(REC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[REC_W-2:0], ge};
			rem_q <= ge ? (RUN_W-1)'(trial - dvs_q) : trial[RUN_W-2:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: hdl/rrlt_owner_ram.sv
// slot owner memory, one write and one registered read port
module rrlt_owner_ram import rrlt_pkg::*; (
	input  logic            clk,
	input  ram_cmd_t        cmd,
	output logic [ID_W-1:0] rdata
);

	logic [ID_W-1:0] mem [MAX_SLOTS];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata_q <= mem[cmd.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rrlt_ctrl.sv
// sequencer: clearing pass, lock lookup and free walk over the owner memory
module rrlt_ctrl import rrlt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [REC_W-1:0]  record_count,
	input  logic [SCNT_W-1:0] slot_count,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              req_type,
	input  logic [REC_W-1:0]  record_number,
	input  logic [ID_W-1:0]   thread_id,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              status,
	output logic [ID_W-1:0]   holder_id,
	output logic              div_start,
	output logic [REC_W-1:0]  div_dividend,
	output logic [RUN_W-1:0]  div_divisor,
	input  logic              div_done,
	input  logic [REC_W-1:0]  div_quotient,
	output ram_cmd_t          ram_cmd,
	input  logic [ID_W-1:0]   ram_rdata
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIV1  = 7'b0000100,
		ST_DIV2  = 7'b0001000,
		ST_LOCK  = 7'b0010000,
		ST_FREE  = 7'b0100000,
		ST_FDONE = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              valid_s1;
	logic [SLOT_W-1:0] addr_s1;
	logic [REC_W-1:0]  rec_q;
	logic [ID_W-1:0]   tid_q;
	logic [SLOT_W-1:0] idx_q;
	logic              rsp_valid_q;
	logic              status_q;
	logic [ID_W-1:0]   holder_q;

	logic [CNT_W-1:0]  n;
	logic              out_free;
	logic              grant;
	logic              free_rd;
	logic              accept;
	logic              emit;
	logic [RUN_W-1:0]  run;
	logic [SLOT_W-1:0] idx_next;

	always_comb begin
		n        = slots_in_use(slot_count);
		out_free = !rsp_valid_q || rsp_ready;
		grant    = (ram_rdata == '0) || (ram_rdata == tid_q);
		free_rd  = (state_q == ST_FREE) && (ptr_q < n);
		accept   = (state_q == ST_IDLE) && req_valid;
		emit     = ((state_q == ST_LOCK) || (state_q == ST_FDONE)) && out_free;
		run      = {1'b0, div_quotient} + RUN_W'(1);
		// record beyond the table lands in the last slot
		if (div_quotient >= REC_W'(n)) begin
			idx_next = SLOT_W'(n - CNT_W'(1));
		end else begin
			idx_next = div_quotient[SLOT_W-1:0];
		end
	end

	// run length first, then the slot index
	always_comb begin
		div_start    = 1'b0;
		div_dividend = record_count;
		div_divisor  = RUN_W'(n);
		if (accept && req_type == REQ_LOCK) begin
			div_start = 1'b1;
		end else if (state_q == ST_DIV1) begin
			div_start    = div_done;
			div_dividend = rec_q;
			div_divisor  = run;
		end
	end

	always_comb begin
		ram_cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = ptr_q[SLOT_W-1:0];
			end
			ST_DIV2: begin
				ram_cmd.re    = div_done;
				ram_cmd.raddr = idx_next;
			end
			ST_LOCK: begin
				ram_cmd.we    = out_free && grant;
				ram_cmd.waddr = idx_q;
				ram_cmd.wdata = tid_q;
			end
			ST_FREE: begin
				// read slot i while slot i-1 is written back
				ram_cmd.re    = free_rd;
				ram_cmd.raddr = ptr_q[SLOT_W-1:0];
				ram_cmd.we    = valid_s1 && (ram_rdata == tid_q);
				ram_cmd.waddr = addr_s1;
			end
			default: begin
				ram_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q == CNT_W'(MAX_SLOTS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						ptr_q    <= '0;
						valid_s1 <= 1'b0;
						state_q  <= (req_type == REQ_FREE) ? ST_FREE : ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_LOCK;
					end
				end
				ST_LOCK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FREE: begin
					valid_s1 <= free_rd;
					if (free_rd) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (!free_rd && !valid_s1) begin
						state_q <= ST_FDONE;
					end
				end
				ST_FDONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q <= record_number;
			tid_q <= thread_id;
		end
		if (state_q == ST_DIV2 && div_done) begin
			idx_q <= idx_next;
		end
		addr_s1 <= ptr_q[SLOT_W-1:0];
		if (emit) begin
			if (state_q == ST_LOCK && !grant) begin
				status_q <= STAT_BUSY;
				holder_q <= ram_rdata;
			end else begin
				status_q <= STAT_OK;
				holder_q <= '0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign holder_id = holder_q;

endmodule

FILE: hdl/rrlt_checker.sv
// port-level checker for the record lock table and its bind
`include "record_range_lock_table_unit_defines.svh"

module rrlt_checker import rrlt_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic            rsp_status,
	input logic [ID_W-1:0] rsp_holder_id
);

	`RRLT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	`RRLT_ASSERT_IMPLIES(a_ok_no_holder, clk, arst_n, rsp_valid && rsp_status == STAT_OK, rsp_holder_id == '0, "success with nonzero holder")

	`RRLT_ASSERT_IMPLIES(a_busy_holder, clk, arst_n, rsp_valid && rsp_status == STAT_BUSY, rsp_holder_id != '0, "busy with free slot")

	`RRLT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready, "item taken while another is in work")

endmodule

bind record_range_lock_table_unit rrlt_checker u_rrlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_holder_id (rsp.holder_id)
);
